// ===== design/apk_pkg.sv =====
`timescale 1ns / 1ps
// Package for the average precision at k unit.
// Holds field widths, fixed-point constants, register indexes and sequencer types.
// No dependencies.
package apk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int CNT_W     = 11;
  localparam int LABEL_W   = 16;
  localparam int SUM_W     = CNT_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(FRAC_W);
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 16;
  localparam int MAX_RANK  = 1024;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  RANK_LIM = CNT_W'(MAX_RANK);
  localparam logic [STEP_W-1:0] LAST_BIT = STEP_W'(FRAC_BITS);

  localparam logic [IDX_W-1:0] REG_CUTOFF   = 2'd0;
  localparam logic [IDX_W-1:0] REG_RELEVANT = 2'd1;
  localparam logic [IDX_W-1:0] REG_QUERY    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_PSUM = 2'd0,
    OP_PREC = 2'd1,
    OP_REC  = 2'd2,
    OP_AP   = 2'd3
  } op_t;

endpackage

// ===== design/average_precision_at_k_unit.sv =====
`timescale 1ns / 1ps
// Average precision at k: one class label per item, one result at the cutoff rank.
// One shared restoring divider (17 quotient bits, one per cycle) under a small sequencer.
// Depends on apk_pkg.
// Sequence: an item that neither matches nor reaches the cutoff is taken in S_IDLE; a match adds
// one division; the cutoff item adds up to three more divisions and an emit state.
// The serial divider sets the rate: in_stall holds off a new item until the sequencer is idle.
// Reset (rst_n low, synchronous) sets cutoff 10, relevant count 1, query class 0, and clears
// rank count, match count, precision sum and the output valid flag.
module average_precision_at_k_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [apk_pkg::LABEL_W-1:0]      in_result_class,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [apk_pkg::FRAC_W-1:0]       out_precision_at_cutoff,
  output logic [apk_pkg::FRAC_W-1:0]       out_recall_at_cutoff,
  output logic [apk_pkg::FRAC_W-1:0]       out_avg_precision,
  output logic [apk_pkg::CNT_W-1:0]        out_match_total,
  output logic                             out_saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apk_pkg::IDX_W-1:0]        cfg_index,
  input  logic [apk_pkg::DATA_W-1:0]       cfg_data
);

  localparam int FW = apk_pkg::FRAC_W;
  localparam int CW = apk_pkg::CNT_W;
  localparam int SW = apk_pkg::SUM_W;
  localparam int FB = apk_pkg::FRAC_BITS;

  apk_pkg::state_t state_r, state_nxt;
  apk_pkg::op_t    op_r, op_nxt;

  logic [CW-1:0]                 cutoff_r, relevant_r;
  logic [apk_pkg::LABEL_W-1:0]   query_r;
  logic [CW-1:0]                 rank_r, rank_nxt;
  logic [CW-1:0]                 match_r, match_nxt;
  logic [SW-1:0]                 psum_r, psum_nxt;
  logic                          done_r, done_nxt;
  logic                          sat_r, sat_nxt;
  logic [FW-1:0]                 prec_r, prec_nxt;
  logic [FW-1:0]                 rec_r, rec_nxt;
  logic [FW-1:0]                 ap_r, ap_nxt;

  logic [SW-1:0]                 div_rem_r, div_rem_nxt;
  logic [SW-1:0]                 div_dsr_r, div_dsr_nxt;
  logic [FW-1:0]                 div_q_r, div_q_nxt;
  logic [apk_pkg::STEP_W-1:0]    div_cnt_r, div_cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [FW-1:0]                 out_prec_r, out_rec_r, out_ap_r;
  logic [CW-1:0]                 out_match_r;
  logic                          out_sat_r;

  logic [CW-1:0]                 k_eff, rel_eff, denom;
  logic                          in_take, out_free;
  logic                          div_ge;
  logic [SW-1:0]                 div_rem_step;
  logic [FW-1:0]                 q_fin;
  logic [CW-1:0]                 rank_inc;
  logic                          is_match;

  always_comb begin
    k_eff = cutoff_r;
    if (cutoff_r == '0) begin
      k_eff = CW'(1);
    end else if (cutoff_r > apk_pkg::RANK_LIM) begin
      k_eff = apk_pkg::RANK_LIM;
    end
    rel_eff = (relevant_r == '0) ? CW'(1) : relevant_r;
    denom   = (rel_eff < k_eff) ? rel_eff : k_eff;
  end

  assign in_stall  = (state_r != apk_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign rank_inc  = rank_r + CW'(1);
  assign is_match  = (in_result_class == query_r);

  assign div_ge       = (div_rem_r >= div_dsr_r);
  assign div_rem_step = div_ge ? (div_rem_r - div_dsr_r) : div_rem_r;
  assign q_fin        = {div_q_r[FW-2:0], div_ge};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rank_nxt      = rank_r;
    match_nxt     = match_r;
    psum_nxt      = psum_r;
    done_nxt      = done_r;
    sat_nxt       = sat_r;
    prec_nxt      = prec_r;
    rec_nxt       = rec_r;
    ap_nxt        = ap_r;
    div_rem_nxt   = div_rem_r;
    div_dsr_nxt   = div_dsr_r;
    div_q_nxt     = div_q_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      apk_pkg::S_IDLE: begin
        if (in_take) begin
          rank_nxt  = rank_inc;
          match_nxt = is_match ? (match_r + CW'(1)) : match_r;
          done_nxt  = (rank_inc >= k_eff);
          sat_nxt   = 1'b0;
          op_nxt    = is_match ? apk_pkg::OP_PSUM : apk_pkg::OP_PREC;
          if (is_match || (rank_inc >= k_eff)) begin
            state_nxt = apk_pkg::S_START;
          end
        end
      end
      apk_pkg::S_START: begin
        div_q_nxt   = '0;
        div_cnt_nxt = apk_pkg::LAST_BIT;
        state_nxt   = apk_pkg::S_DIV;
        unique case (op_r) inside
          apk_pkg::OP_PSUM, apk_pkg::OP_PREC: begin
            div_rem_nxt = {match_r, FB'(0)};
            div_dsr_nxt = {rank_r, FB'(0)};
          end
          apk_pkg::OP_REC: begin
            div_rem_nxt = {match_r, FB'(0)};
            div_dsr_nxt = {rel_eff, FB'(0)};
            if (match_r > rel_eff) begin
              rec_nxt   = apk_pkg::FRAC_ONE;
              sat_nxt   = 1'b1;
              op_nxt    = apk_pkg::OP_AP;
              state_nxt = apk_pkg::S_START;
            end
          end
          apk_pkg::OP_AP: begin
            div_rem_nxt = psum_r;
            div_dsr_nxt = {denom, FB'(0)};
            if ({1'b0, psum_r} >= {denom, FW'(0)}) begin
              ap_nxt    = apk_pkg::FRAC_ONE;
              sat_nxt   = 1'b1;
              state_nxt = apk_pkg::S_EMIT;
            end
          end
          default: begin
            state_nxt = apk_pkg::S_IDLE;
          end
        endcase
      end
      apk_pkg::S_DIV: begin
        div_rem_nxt = div_rem_step;
        div_dsr_nxt = div_dsr_r >> 1;
        div_q_nxt   = q_fin;
        div_cnt_nxt = div_cnt_r - apk_pkg::STEP_W'(1);
        if (div_cnt_r == '0) begin
          unique case (op_r)
            apk_pkg::OP_PSUM: begin
              psum_nxt  = psum_r + SW'(q_fin);
              op_nxt    = apk_pkg::OP_PREC;
              state_nxt = done_r ? apk_pkg::S_START : apk_pkg::S_IDLE;
            end
            apk_pkg::OP_PREC: begin
              prec_nxt  = q_fin;
              op_nxt    = apk_pkg::OP_REC;
              state_nxt = apk_pkg::S_START;
            end
            apk_pkg::OP_REC: begin
              rec_nxt   = q_fin;
              op_nxt    = apk_pkg::OP_AP;
              state_nxt = apk_pkg::S_START;
            end
            apk_pkg::OP_AP: begin
              if (q_fin > apk_pkg::FRAC_ONE) begin
                ap_nxt  = apk_pkg::FRAC_ONE;
                sat_nxt = 1'b1;
              end else begin
                ap_nxt = q_fin;
              end
              state_nxt = apk_pkg::S_EMIT;
            end
            default: begin
              state_nxt = apk_pkg::S_IDLE;
            end
          endcase
        end
      end
      apk_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          rank_nxt      = '0;
          match_nxt     = '0;
          psum_nxt      = '0;
          state_nxt     = apk_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = apk_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apk_pkg::S_IDLE;
      op_r        <= apk_pkg::OP_PSUM;
      cutoff_r    <= CW'(10);
      relevant_r  <= CW'(1);
      query_r     <= '0;
      rank_r      <= '0;
      match_r     <= '0;
      psum_r      <= '0;
      done_r      <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      rank_r      <= rank_nxt;
      match_r     <= match_nxt;
      psum_r      <= psum_nxt;
      done_r      <= done_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apk_pkg::REG_CUTOFF:   cutoff_r   <= cfg_data[CW-1:0];
          apk_pkg::REG_RELEVANT: relevant_r <= cfg_data[CW-1:0];
          apk_pkg::REG_QUERY:    query_r    <= cfg_data[apk_pkg::LABEL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prec_r    <= prec_nxt;
    rec_r     <= rec_nxt;
    ap_r      <= ap_nxt;
    div_rem_r <= div_rem_nxt;
    div_dsr_r <= div_dsr_nxt;
    div_q_r   <= div_q_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (state_r == apk_pkg::S_EMIT && out_free) begin
      out_prec_r  <= prec_r;
      out_rec_r   <= rec_r;
      out_ap_r    <= ap_r;
      out_match_r <= match_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_precision_at_cutoff = out_prec_r;
  assign out_recall_at_cutoff    = out_rec_r;
  assign out_avg_precision       = out_ap_r;
  assign out_match_total         = out_match_r;
  assign out_saturated           = out_sat_r;

`ifndef SYNTHESIS
  a_match_le_rank: assert property (@(posedge clk) disable iff (!rst_n)
    match_r <= rank_r)
    else $error("match count above rank count");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rank_r <= apk_pkg::RANK_LIM)
    else $error("rank count above maximum rank");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == apk_pkg::S_DIV |-> {1'b0, div_rem_r} < {div_dsr_r, 1'b0})
    else $error("divider remainder out of range, quotient would overflow");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apk_pkg::S_EMIT && out_free) |=> (rank_r == '0 && psum_r == '0))
    else $error("state not cleared after emit");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_prec_r <= apk_pkg::FRAC_ONE && out_rec_r <= apk_pkg::FRAC_ONE &&
                     out_ap_r <= apk_pkg::FRAC_ONE))
    else $error("result fraction above 1.0");
`endif

endmodule

// ===== tb/sv/tb_average_precision_at_k_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for average_precision_at_k_unit: ranked labels in, one score per list.
// A scoreboard class predicts each score from the labels and register writes it observes.
// Depends on apk_pkg and the average_precision_at_k_unit RTL.
module tb_average_precision_at_k_unit;

  localparam int FRAC_BITS = apk_pkg::FRAC_BITS;
  localparam int FRAC_W    = apk_pkg::FRAC_W;
  localparam int CNT_W     = apk_pkg::CNT_W;
  localparam int LABEL_W   = apk_pkg::LABEL_W;
  localparam int IDX_W     = apk_pkg::IDX_W;
  localparam int DATA_W    = apk_pkg::DATA_W;
  localparam int MAX_RANK  = apk_pkg::MAX_RANK;

  typedef struct packed {
    logic [FRAC_W-1:0] precision;
    logic [FRAC_W-1:0] recall;
    logic [FRAC_W-1:0] avg_prec;
    logic [CNT_W-1:0]  match_tot;
    logic              saturated;
  } ap_score_t;

  class ap_scoreboard;
    logic [CNT_W-1:0]   cutoff;
    logic [CNT_W-1:0]   relevant;
    logic [LABEL_W-1:0] query;
    int unsigned        rank_cnt;
    int unsigned        match_cnt;
    longint unsigned    prec_sum;
    ap_score_t          scores[$];
    int unsigned        mismatches;
    int unsigned        labels_seen;
    int unsigned        scores_seen;
    int unsigned        reg_writes;

    function new();
      cutoff      = 11'd10;
      relevant    = 11'd1;
      query       = '0;
      rank_cnt    = 0;
      match_cnt   = 0;
      prec_sum    = 0;
      mismatches  = 0;
      labels_seen = 0;
      scores_seen = 0;
      reg_writes  = 0;
    endfunction

    function int unsigned eff_cutoff();
      if (cutoff == 0) return 1;
      if (cutoff > MAX_RANK) return MAX_RANK;
      return cutoff;
    endfunction

    function int unsigned pending();
      return scores.size();
    endfunction

    function longint unsigned frac_quot(longint unsigned num, longint unsigned den);
      return (num << FRAC_BITS) / den;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        apk_pkg::REG_CUTOFF:   cutoff = data[CNT_W-1:0];
        apk_pkg::REG_RELEVANT: relevant = data[CNT_W-1:0];
        apk_pkg::REG_QUERY:    query = data[LABEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_label(logic [LABEL_W-1:0] label);
      longint unsigned one;
      longint unsigned prec;
      longint unsigned rec;
      longint unsigned ap;
      int unsigned     k;
      int unsigned     rel;
      int unsigned     den;
      ap_score_t       s;
      one = 64'd1 << FRAC_BITS;
      k   = eff_cutoff();
      rel = (relevant == 0) ? 1 : relevant;
      labels_seen++;
      rank_cnt++;
      if (label == query) begin
        match_cnt++;
        prec_sum += frac_quot(match_cnt, rank_cnt);
      end
      if (rank_cnt < k) return;
      s.saturated = 1'b0;
      prec = frac_quot(match_cnt, rank_cnt);
      if (prec > one) prec = one;
      rec = frac_quot(match_cnt, rel);
      if (rec > one) begin
        rec = one;
        s.saturated = 1'b1;
      end
      den = (rel < k) ? rel : k;
      ap = prec_sum / den;
      if (ap > one) begin
        ap = one;
        s.saturated = 1'b1;
      end
      s.precision = prec[FRAC_W-1:0];
      s.recall    = rec[FRAC_W-1:0];
      s.avg_prec  = ap[FRAC_W-1:0];
      s.match_tot = match_cnt[CNT_W-1:0];
      scores = {scores, s};
      rank_cnt  = 0;
      match_cnt = 0;
      prec_sum  = 0;
    endfunction

    function void check_score(ap_score_t got);
      ap_score_t want;
      string     bad;
      scores_seen++;
      if (scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: prec %0d rec %0d ap %0d matches %0d sat %0d",
                   got.precision, got.recall, got.avg_prec, got.match_tot, got.saturated);
        return;
      end
      want = scores.pop_front();
      bad  = "";
      if (got.precision !== want.precision) bad = {bad, " precision"};
      if (got.recall !== want.recall) bad = {bad, " recall"};
      if (got.avg_prec !== want.avg_prec) bad = {bad, " avg_precision"};
      if (got.match_tot !== want.match_tot) bad = {bad, " match_total"};
      if (got.saturated !== want.saturated) bad = {bad, " saturated"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on%s: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d", bad,
                   want.precision, want.recall, want.avg_prec, want.match_tot, want.saturated,
                   got.precision, got.recall, got.avg_prec, got.match_tot, got.saturated);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [LABEL_W-1:0] in_result_class;
  logic               out_valid;
  logic               out_stall;
  logic [FRAC_W-1:0]  out_precision_at_cutoff;
  logic [FRAC_W-1:0]  out_recall_at_cutoff;
  logic [FRAC_W-1:0]  out_avg_precision;
  logic [CNT_W-1:0]   out_match_total;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]  cfg_data;

  ap_scoreboard sb;
  ap_score_t    seen_score;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  sent_count;

  average_precision_at_k_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_result_class         (in_result_class),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_precision_at_cutoff (out_precision_at_cutoff),
    .out_recall_at_cutoff    (out_recall_at_cutoff),
    .out_avg_precision       (out_avg_precision),
    .out_match_total         (out_match_total),
    .out_saturated           (out_saturated),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_label(in_result_class);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        seen_score.precision = out_precision_at_cutoff;
        seen_score.recall    = out_recall_at_cutoff;
        seen_score.avg_prec  = out_avg_precision;
        seen_score.match_tot = out_match_total;
        seen_score.saturated = out_saturated;
        sb.check_score(seen_score);
      end
    end
  end

  task automatic send_label(input logic [LABEL_W-1:0] label);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_result_class <= label;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_segment();
    int unsigned       k;
    int unsigned       n;
    int unsigned       r;
    int unsigned       hit_pct;
    logic [DATA_W-1:0] data;
    logic [LABEL_W-1:0] label;
    drain_idle();
    if ($urandom_range(99) < 60) begin
      r    = $urandom_range(99);
      data = DATA_W'($urandom_range(65535));
      if (r < 4) data[CNT_W-1:0] = '0;
      else if (r < 80) data[CNT_W-1:0] = CNT_W'($urandom_range(1, 12));
      else if (r < 95) data[CNT_W-1:0] = CNT_W'($urandom_range(13, 64));
      else data[CNT_W-1:0] = CNT_W'($urandom_range(65, 160));
      cfg_write(apk_pkg::REG_CUTOFF, data);
    end
    k = sb.eff_cutoff();
    if ($urandom_range(99) < 60) begin
      r    = $urandom_range(99);
      data = DATA_W'($urandom_range(65535));
      if (r < 5) data[CNT_W-1:0] = '0;
      else if (r < 55) data[CNT_W-1:0] = CNT_W'($urandom_range(1, k));
      else if (r < 80) data[CNT_W-1:0] = CNT_W'($urandom_range(k + 1, k + 20));
      else data[CNT_W-1:0] = CNT_W'($urandom_range(2047));
      cfg_write(apk_pkg::REG_RELEVANT, data);
    end
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 10) cfg_write(apk_pkg::REG_QUERY, '0);
      else if (r < 20) cfg_write(apk_pkg::REG_QUERY, '1);
      else cfg_write(apk_pkg::REG_QUERY, DATA_W'($urandom_range(65535)));
    end
    r = $urandom_range(99);
    if (r < 10) hit_pct = 0;
    else if (r < 25) hit_pct = 100;
    else hit_pct = $urandom_range(5, 95);
    if ($urandom_range(99) < 80) n = k * $urandom_range(1, 3);
    else n = $urandom_range(1, k + 3);
    repeat (n) begin
      if ($urandom_range(99) < hit_pct) label = sb.query;
      else label = LABEL_W'($urandom_range(65535));
      send_label(label);
    end
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = sent_count + 335;
    while (sent_count < stop_at) random_segment();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_result_class = '0;
    cfg_valid       = 1'b0;
    cfg_index       = apk_pkg::REG_CUTOFF;
    cfg_data        = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    sent_count      = 0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_label(16'h0000);
    send_label(16'hFFFF);
    send_label(16'h0000);
    send_label(16'h0000);
    send_label(16'h0001);
    send_label(16'h8000);
    send_label(16'h0000);
    send_label(16'hFFFE);
    send_label(16'h0000);
    send_label(16'h7FFF);
    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'h0001);
    cfg_write(apk_pkg::REG_RELEVANT, 16'h0400);
    cfg_write(apk_pkg::REG_QUERY, 16'hFFFF);
    send_label(16'hFFFF);
    send_label(16'h0000);
    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'hF800);
    cfg_write(apk_pkg::REG_RELEVANT, 16'hF800);
    send_label(16'hFFFF);
    send_label(16'hFFFF);
    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'hF400);
    cfg_write(apk_pkg::REG_RELEVANT, 16'h0003);
    cfg_write(apk_pkg::REG_QUERY, 16'h1234);
    send_label(16'h1234);
    send_label(16'h0000);
    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'h0002);
    send_label(16'h1234);
    drain_idle();

    random_phase(14, 73);
    random_phase(73, 14);
    random_phase(0, 0);

    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'hFFFF);
    cfg_write(apk_pkg::REG_RELEVANT, 16'hF7FF);
    cfg_write(apk_pkg::REG_QUERY, DATA_W'($urandom_range(65535)));
    repeat (24) begin
      if ($urandom_range(99) < 30) send_label(sb.query);
      else send_label(LABEL_W'($urandom_range(65535)));
    end
    drain_idle();
    cfg_write(apk_pkg::REG_CUTOFF, 16'h0003);
    send_label(sb.query);
    drain_idle();

    $display("Run covered %0d labels, %0d scored lists and %0d register writes,",
             sb.labels_seen, sb.scores_seen, sb.reg_writes);
    $display("across three idle mixes, mid-list writes and a clamped cutoff list.");
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[average_precision_at_k_unit] OK");
    end else begin
      $display("[average_precision_at_k_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout after %0d labels", sent_count);
    $display("[average_precision_at_k_unit] ERROR");
    $finish;
  end

endmodule
